// ===== rtl/core/dbma_pkg.sv =====
// shared types and constants for the daily bar moving average engine
package dbma_pkg;

    localparam int unsigned PriceW  = 24;
    localparam int unsigned VolW    = 40;
    localparam int unsigned RatioW  = 32;
    localparam int unsigned GapW    = 3;
    localparam int unsigned NumWin  = 6;

    typedef struct packed {
        logic [PriceW-1:0] open_price;
        logic [PriceW-1:0] high_price;
        logic [PriceW-1:0] low_price;
        logic [PriceW-1:0] close_price;
        logic [VolW-1:0]   volume;
    } t_bar_in;

    typedef struct packed {
        logic [PriceW-1:0] prior_close;
        logic [PriceW-1:0] ma_5;
        logic [PriceW-1:0] ma_10;
        logic [PriceW-1:0] ma_20;
        logic [PriceW-1:0] ma_60;
        logic [PriceW-1:0] ma_120;
        logic [PriceW-1:0] ma_250;
        logic [RatioW-1:0] volume_ratio;
        logic [GapW-1:0]   gap_class;
    } t_bar_out;

    localparam logic [GapW-1:0] GapNone     = 3'd0;
    localparam logic [GapW-1:0] GapDown     = 3'd1;
    localparam logic [GapW-1:0] GapLowOpen  = 3'd2;
    localparam logic [GapW-1:0] GapUp       = 3'd3;
    localparam logic [GapW-1:0] GapHighOpen = 3'd4;

    localparam logic [RatioW-1:0] RatioOne = 32'h0001_0000;
    localparam logic [RatioW-1:0] RatioSat = 32'hFFFF_FFFF;

    // divider command and status between the sequencer and the divider
    typedef struct packed {
        logic start;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/core/dbma_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module dbma_divider #(
    parameter int unsigned NUM_W = 64,
    parameter int unsigned DEN_W = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dbma_pkg::t_div_cmd     i_cmd,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    output dbma_pkg::t_div_sts     o_sts,
    output logic [NUM_W-1:0]       o_quot
);
    import dbma_pkg::*;

    localparam int unsigned CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb begin
        shifted = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        n_quot  = {r_quot[NUM_W-2:0], 1'b0};
        n_rem   = shifted;
        if (!diff[DEN_W]) begin
            n_rem     = diff;
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_cmd.start |=> r_busy || r_done) else $error("divider dropped busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");

endmodule

// ===== rtl/core/daily_bar_moving_average_engine.sv =====
// top level: bar history, window sums, sequencer and result register
// One bar beat is taken at a time, and ready stays low until the result beat
// of that bar has been taken. For each of the six windows the engine adds the
// new close to the window sum. It reads the close that leaves the window from
// the history memory (one read per cycle) and subtracts it. It then divides
// the sum by the number of bars available. A seventh division gives the
// Q16.16 volume ratio: (volume * count) << 16 over the sum of the earlier
// volumes, saturated to 32 bits. All seven divisions share one restoring
// divider that takes 64 steps each, so the divider sets the time per bar.
// A window pass runs add, subtract, issue, the 64 divider steps and done. The
// ratio pass runs issue, the divider steps and done; it is skipped when the
// ratio needs no division (the first bar, or earlier volumes that sum to
// zero). The next bar can be accepted on the edge after the result beat is
// taken. Back pressure on the result stalls the input cycle for cycle. The
// close history is a 256-entry memory that needs no clearing, because the
// value read from an entry is used only after the entry was written. The
// first bar returns prior close zero, gap none and a ratio of 1.0. A zero
// earlier-volume sum saturates the ratio.
module daily_bar_moving_average_engine #(
    parameter int unsigned LONGEST_WINDOW = 250,
    parameter int unsigned VOLUME_DAYS    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dbma_pkg::t_bar_in  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dbma_pkg::t_bar_out o_data
);
    import dbma_pkg::*;

    localparam int unsigned RingD  = 256;
    localparam int unsigned RingAW = 8;
    localparam int unsigned SumW   = 32;
    localparam int unsigned VSumW  = VolW + $clog2(VOLUME_DAYS + 1);
    localparam int unsigned NumW   = 64;
    localparam int unsigned DenW   = VSumW;
    localparam int unsigned VpW    = (VOLUME_DAYS > 1) ? $clog2(VOLUME_DAYS) : 1;
    localparam int unsigned BsW    = 9;
    localparam int unsigned WinIdxW = 3;
    localparam int unsigned FracW  = 16;
    localparam int unsigned VProdW = VolW + VpW + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_SUB   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    // clamped window length for each slot
    function automatic logic [BsW-1:0] win_len(input logic [WinIdxW-1:0] k);
        int unsigned w;
        begin
            unique case (k)
                3'd0:    w = 5;
                3'd1:    w = 10;
                3'd2:    w = 20;
                3'd3:    w = 60;
                3'd4:    w = 120;
                default: w = LONGEST_WINDOW;
            endcase
            if (w > LONGEST_WINDOW) w = LONGEST_WINDOW;
            return BsW'(w);
        end
    endfunction

    t_state r_state;
    t_bar_in r_in;
    t_bar_out r_out;
    logic r_out_valid;

    logic [PriceW-1:0] r_ring [RingD];
    logic [PriceW-1:0] r_ring_q;
    logic [RingAW-1:0] r_cptr;

    logic [VolW-1:0]  r_vring [VOLUME_DAYS];
    logic [VpW-1:0]   r_vptr;
    logic [VSumW-1:0] r_vsum;

    logic [SumW-1:0]   r_sums [NumWin];
    logic [BsW-1:0]    r_seen;
    logic [PriceW-1:0] r_last_high, r_last_low, r_last_close;
    logic [WinIdxW-1:0] r_k;

    t_div_cmd div_cmd;
    t_div_sts div_sts;
    logic [NumW-1:0] div_num, div_quot;
    logic [DenW-1:0] div_den;

    logic [BsW-1:0]    wl, cnt_n;
    logic [RingAW-1:0] rd_idx;
    logic [VpW:0]      vcount;
    logic [VProdW-1:0] vprod;
    logic [RatioW-1:0] ratio;
    logic [GapW-1:0]   gap;

    assign wl     = win_len(r_k);
    assign rd_idx = (wl >= BsW'(RingD)) ? r_cptr : RingAW'(r_cptr - wl[RingAW-1:0]);
    assign cnt_n  = (r_seen + 1'b1 > wl) ? wl : r_seen + 1'b1;
    assign vcount = (r_seen < BsW'(VOLUME_DAYS)) ? (VpW+1)'(r_seen) : (VpW+1)'(VOLUME_DAYS);
    // count is at most VOLUME_DAYS, so the product stays within VProdW bits
    assign vprod  = VProdW'(r_in.volume) * VProdW'(vcount);

    always_comb begin
        div_cmd.start = (r_state == ST_DIV);
        if (r_k == WinIdxW'(NumWin)) begin
            div_num = NumW'({vprod, {FracW{1'b0}}});
            div_den = r_vsum;
        end else begin
            div_num = NumW'(r_sums[r_k]);
            div_den = DenW'(cnt_n);
        end
    end

    dbma_divider #(.NUM_W(NumW), .DEN_W(DenW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (div_cmd),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_sts  (div_sts),
        .o_quot (div_quot)
    );

    // ratio: the scaled product fits in 64 bits, so one division gives all
    // 16 fraction bits; a quotient of 2^32 or more saturates
    always_comb begin
        if (div_quot[NumW-1:RatioW] != '0) ratio = RatioSat;
        else ratio = div_quot[RatioW-1:0];
    end

    // opening gap against the previous bar, high side wins
    always_comb begin
        gap = GapNone;
        if (r_seen != '0) begin
            if (r_in.open_price < r_last_low) gap = GapDown;
            else if (r_in.open_price < r_last_close) gap = GapLowOpen;
            if (r_in.open_price > r_last_high) gap = GapUp;
            else if (r_in.open_price > r_last_close) gap = GapHighOpen;
        end
    end

    // history memory, registered read
    always_ff @(posedge i_clk) begin
        r_ring_q <= r_ring[rd_idx];
        if (r_state == ST_FIN) r_ring[r_cptr] <= r_in.close_price;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_cptr       <= '0;
            r_vptr       <= '0;
            r_vsum       <= '0;
            r_seen       <= '0;
            r_last_high  <= '0;
            r_last_low   <= '0;
            r_last_close <= '0;
            r_k          <= '0;
            for (int i = 0; i < NumWin; i++) r_sums[i] <= '0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in  <= i_data;
                        r_k   <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_sums[r_k] <= r_sums[r_k] + SumW'(r_in.close_price);
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    if (r_seen >= wl) r_sums[r_k] <= r_sums[r_k] - SumW'(r_ring_q);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_sts.done) begin
                        if (r_k == WinIdxW'(NumWin)) begin
                            r_out.volume_ratio <= ratio;
                            r_state <= ST_FIN;
                        end else begin
                            unique case (r_k)
                                3'd0:    r_out.ma_5   <= PriceW'(div_quot);
                                3'd1:    r_out.ma_10  <= PriceW'(div_quot);
                                3'd2:    r_out.ma_20  <= PriceW'(div_quot);
                                3'd3:    r_out.ma_60  <= PriceW'(div_quot);
                                3'd4:    r_out.ma_120 <= PriceW'(div_quot);
                                default: r_out.ma_250 <= PriceW'(div_quot);
                            endcase
                            r_k <= r_k + 1'b1;
                            if (r_k == WinIdxW'(NumWin - 1)) begin
                                if (vcount == '0 || r_vsum == '0) r_state <= ST_FIN;
                                else r_state <= ST_DIV;
                            end else begin
                                r_state <= ST_READ;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    r_out.prior_close <= r_last_close;
                    if (vcount == '0) r_out.volume_ratio <= RatioOne;
                    else if (r_vsum == '0) r_out.volume_ratio <= RatioSat;
                    r_out.gap_class <= gap;
                    r_cptr <= r_cptr + 1'b1;
                    r_vsum <= r_vsum + DenW'(r_in.volume)
                            - ((vcount == (VpW+1)'(VOLUME_DAYS)) ? DenW'(r_vring[r_vptr]) : '0);
                    r_vring[r_vptr] <= r_in.volume;
                    r_vptr <= (r_vptr == VpW'(VOLUME_DAYS - 1)) ? '0 : r_vptr + 1'b1;
                    if (r_seen < BsW'(LONGEST_WINDOW)) r_seen <= r_seen + 1'b1;
                    r_last_high  <= r_in.high_price;
                    r_last_low   <= r_in.low_price;
                    r_last_close <= r_in.close_price;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_seen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= BsW'(LONGEST_WINDOW)) else $error("bar count overran");
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == ST_READ) else $error("accept not started");

endmodule
